// ===== hdl/ddct_pkg.sv =====
// Package for the dual down-counter timer: beat types, operation codes,
// register offsets and identification constants. No dependencies.
package ddct_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [31:0] write_data;
  } ddct_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_one;
    logic        irq_two;
    logic        irq_combined;
  } ddct_out_t;

  // Command from the top level to one timer for the current beat.
  typedef struct packed {
    logic        tick;
    logic        wr;
    logic [4:0]  off;
    logic [31:0] data;
  } ddct_cmd_t;

  // What one timer reports back for the current beat.
  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_next;
  } ddct_stat_t;

  localparam logic [4:0] OFF_LOAD   = 5'h00;
  localparam logic [4:0] OFF_VALUE  = 5'h04;
  localparam logic [4:0] OFF_CTRL   = 5'h08;
  localparam logic [4:0] OFF_INTCLR = 5'h0C;
  localparam logic [4:0] OFF_RIS    = 5'h10;
  localparam logic [4:0] OFF_MIS    = 5'h14;
  localparam logic [4:0] OFF_BGLOAD = 5'h18;

  localparam logic [11:0] TIMER_SPAN        = 12'h020;
  localparam logic [11:0] SECOND_TIMER_BASE = 12'h020;

  localparam logic [11:0] ADDR_ITCR    = 12'hF00;
  localparam logic [7:0]  ADDR_PID_HI  = 8'hFE;
  localparam logic [7:0]  ADDR_CID_HI  = 8'hFF;

  localparam int unsigned CTL_ENABLE   = 7;
  localparam int unsigned CTL_PERIODIC = 6;
  localparam int unsigned CTL_INTEN    = 5;
  localparam int unsigned CTL_SIZE32   = 1;
  localparam int unsigned CTL_ONESHOT  = 0;
  localparam logic [7:0]  CTL_MASK     = 8'hEF;
  localparam logic [7:0]  CTL_RESET    = 8'h20;

  localparam logic [1:0] PSC_DIV1  = 2'd0;
  localparam logic [1:0] PSC_DIV16 = 2'd1;

  localparam logic [31:0] PERIPH_ID = 32'd1316868;
  localparam logic [31:0] CELL_ID   = 32'd2970939405;

endpackage

// ===== hdl/ddct_timer.sv =====
// One down-counting timer: load, control, count, prescaler and interrupt flag.
// Uses ddct_pkg for the command and status types and register offsets.
module ddct_timer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddct_pkg::ddct_cmd_t   cmd_i,
  output ddct_pkg::ddct_stat_t  stat_o
);

  logic [31:0] reload_q, reload_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [31:0] count_q, count_d;
  logic [7:0]  presc_q, presc_d;
  logic        run_q, run_d;
  logic        irq_q, irq_d;

  logic        presc_inc;
  logic [31:0] mask_cur;
  logic [31:0] mask_new;

  always_comb begin
    mask_cur = ctrl_q[ddct_pkg::CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    case (ctrl_q[3:2])
      ddct_pkg::PSC_DIV1:  presc_inc = 1'b0;
      ddct_pkg::PSC_DIV16: presc_inc = (presc_q < 8'd15);
      default:             presc_inc = (presc_q != 8'hFF);
    endcase
  end

  always_comb begin
    reload_d = reload_q;
    ctrl_d   = ctrl_q;
    count_d  = count_q;
    presc_d  = presc_q;
    run_d    = run_q;
    irq_d    = irq_q;
    mask_new = mask_cur;

    if (cmd_i.tick) begin
      if (ctrl_q[ddct_pkg::CTL_ENABLE] && run_q) begin
        if (presc_inc) begin
          presc_d = presc_q + 8'd1;
        end else begin
          presc_d = '0;
          if (count_q > 32'd1) begin
            count_d = count_q - 32'd1;
          end else begin
            irq_d = ctrl_q[ddct_pkg::CTL_INTEN];
            if (ctrl_q[ddct_pkg::CTL_ONESHOT]) begin
              count_d = '0;
              run_d   = 1'b0;
            end else if (ctrl_q[ddct_pkg::CTL_PERIODIC]) begin
              count_d = reload_q & mask_cur;
            end else begin
              count_d = mask_cur;
            end
          end
        end
      end
    end else if (cmd_i.wr) begin
      case (cmd_i.off)
        ddct_pkg::OFF_LOAD: begin
          reload_d = cmd_i.data;
          count_d  = cmd_i.data & mask_cur;
          presc_d  = '0;
          run_d    = ctrl_q[ddct_pkg::CTL_ENABLE];
        end
        ddct_pkg::OFF_CTRL: begin
          // The restart sees the freshly written size and enable bits.
          ctrl_d   = cmd_i.data[7:0] & ddct_pkg::CTL_MASK;
          mask_new = cmd_i.data[ddct_pkg::CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
          count_d  = reload_q & mask_new;
          presc_d  = '0;
          run_d    = cmd_i.data[ddct_pkg::CTL_ENABLE];
        end
        ddct_pkg::OFF_INTCLR: irq_d = 1'b0;
        ddct_pkg::OFF_BGLOAD: reload_d = cmd_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.irq_next = irq_d;
    case (cmd_i.off)
      ddct_pkg::OFF_LOAD:   stat_o.rdata = reload_q;
      ddct_pkg::OFF_VALUE:  stat_o.rdata = ctrl_q[ddct_pkg::CTL_ENABLE] ? count_q : reload_q;
      ddct_pkg::OFF_CTRL:   stat_o.rdata = {24'd0, ctrl_q};
      ddct_pkg::OFF_RIS:    stat_o.rdata = {31'd0, irq_q};
      ddct_pkg::OFF_MIS:    stat_o.rdata = {31'd0, irq_q & ctrl_q[ddct_pkg::CTL_INTEN]};
      ddct_pkg::OFF_BGLOAD: stat_o.rdata = reload_q;
      default:              stat_o.rdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      ctrl_q   <= ddct_pkg::CTL_RESET;
      count_q  <= 32'hFFFF_FFFF;
      presc_q  <= '0;
      run_q    <= 1'b0;
      irq_q    <= 1'b0;
    end else begin
      reload_q <= reload_d;
      ctrl_q   <= ctrl_d;
      count_q  <= count_d;
      presc_q  <= presc_d;
      run_q    <= run_d;
      irq_q    <= irq_d;
    end
  end

endmodule

// ===== hdl/dual_down_counter_timer.sv =====
// Dual down-counter timer top level: input register, address decode, two timers,
// identification registers and result register. Depends on ddct_pkg, ddct_timer.
//
// Usage: every input beat is either one timer-clock tick (applied to both timers),
// a register read or a register write. Each accepted beat produces exactly one
// result beat carrying the read data (zero unless a mapped read) and both timer
// interrupt lines as they stand after the beat, plus their OR.
// Both channels use valid/ready. A beat is accepted when valid and ready are high.
// An accepted beat sits in the input register while the timers update from it, and
// the result register loads at the same edge as the timer state, once it is free or
// its beat is being taken.
// Throughput is one beat per cycle while the receiver takes results; the timer state update is a single pass of
// decode, a 32-bit decrement and selection between the input and result registers.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more; in_ready_o drops only while both are full and the
// receiver is not taking the result.
// Reset clears both pipeline valids, the timer state to its documented reset
// values and the test control register; no beats are in flight afterwards.
module dual_down_counter_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ddct_pkg::ddct_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ddct_pkg::ddct_out_t  out_data_o
);

  logic                 in_vld_q;
  ddct_pkg::ddct_in_t   in_item_q;
  logic                 out_vld_q;
  ddct_pkg::ddct_out_t  out_item_q, out_item_d;
  logic [31:0]          test_ctl_q, test_ctl_d;

  logic                 adv;
  logic                 is_tick, is_read, is_write, aligned;
  logic                 hit_one, hit_tmr, sel_two;
  logic [11:0]          two_off;
  logic [4:0]           tmr_off;
  ddct_pkg::ddct_cmd_t  cmd_one, cmd_two;
  ddct_pkg::ddct_stat_t stat_one, stat_two;
  logic [31:0]          misc_rdata;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  assign is_tick  = in_item_q.operation == ddct_pkg::OP_TICK;
  assign is_read  = in_item_q.operation == ddct_pkg::OP_READ;
  assign is_write = in_item_q.operation == ddct_pkg::OP_WRITE;
  // Timer one sits at the bottom of the map, timer two at its own base.
  assign hit_one  = in_item_q.address < ddct_pkg::TIMER_SPAN;
  assign two_off  = in_item_q.address - ddct_pkg::SECOND_TIMER_BASE;
  assign sel_two  = !hit_one && (in_item_q.address >= ddct_pkg::SECOND_TIMER_BASE)
                    && (two_off < ddct_pkg::TIMER_SPAN);
  assign hit_tmr  = hit_one || sel_two;
  assign tmr_off  = sel_two ? two_off[4:0] : in_item_q.address[4:0];
  assign aligned  = tmr_off[1:0] == 2'b00;

  always_comb begin
    cmd_one.tick = adv && is_tick;
    cmd_one.wr   = adv && is_write && aligned && hit_one;
    cmd_one.off  = tmr_off;
    cmd_one.data = in_item_q.write_data;
    cmd_two      = cmd_one;
    cmd_two.wr   = adv && is_write && aligned && sel_two;
  end

  ddct_timer u_tmr_one (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_one),
    .stat_o (stat_one)
  );

  ddct_timer u_tmr_two (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_two),
    .stat_o (stat_two)
  );

  always_comb begin
    test_ctl_d = test_ctl_q;
    if (adv && is_write && !hit_tmr && in_item_q.address == ddct_pkg::ADDR_ITCR) begin
      test_ctl_d = in_item_q.write_data;
    end
  end

  always_comb begin
    misc_rdata = '0;
    if (in_item_q.address == ddct_pkg::ADDR_ITCR) begin
      misc_rdata = test_ctl_q;
    end else if (in_item_q.address[11:4] == ddct_pkg::ADDR_PID_HI) begin
      misc_rdata = {24'd0, ddct_pkg::PERIPH_ID[{in_item_q.address[3:2], 3'b000} +: 8]};
    end else if (in_item_q.address[11:4] == ddct_pkg::ADDR_CID_HI) begin
      misc_rdata = {24'd0, ddct_pkg::CELL_ID[{in_item_q.address[3:2], 3'b000} +: 8]};
    end
  end

  always_comb begin
    out_item_d.read_data = '0;
    if (is_read && aligned) begin
      if (hit_tmr) begin
        out_item_d.read_data = sel_two ? stat_two.rdata : stat_one.rdata;
      end else begin
        out_item_d.read_data = misc_rdata;
      end
    end
    out_item_d.irq_one      = stat_one.irq_next;
    out_item_d.irq_two      = stat_two.irq_next;
    out_item_d.irq_combined = stat_one.irq_next | stat_two.irq_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      test_ctl_q <= '0;
    end else begin
      test_ctl_q <= test_ctl_d;
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

endmodule

// ===== hdl/ddct_checker.sv =====
// Port-level checks for the dual down-counter timer, bound to the top level.
// Depends on ddct_pkg and dual_down_counter_timer.
module ddct_port_checks (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ddct_pkg::ddct_out_t out_data_i
);

  // A stalled result beat must stay put until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed or dropped while stalled");

  // While a result is valid, the combined line is the OR of the two timer lines.
  a_irq_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.irq_combined == (out_data_i.irq_one | out_data_i.irq_two))
    else $error("combined irq does not match the timer irqs");

  // The input side only backs up when a result is waiting and not being taken.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input not ready without an output stall");

  // An accepted input beat is followed by a valid result on the output.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 out_valid_i)
    else $error("no result beat after an accepted input beat");

endmodule

bind dual_down_counter_timer ddct_port_checks u_ddct_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ===== verif/ddct_checker.sv =====
`timescale 1ns / 100ps
// Checker for the dual down-counter timer: watches both channels, predicts each result
// beat from its own timer state and compares. Depends on ddct_pkg.
module ddct_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ddct_pkg::ddct_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ddct_pkg::ddct_out_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  logic [31:0] reload_val   [0:1];
  logic [7:0]  ctrl_bits    [0:1];
  logic [31:0] count_val    [0:1];
  logic [7:0]  prescale_cnt [0:1];
  logic        running      [0:1];
  logic        irq_flag     [0:1];
  logic [31:0] test_ctrl;

  ddct_pkg::ddct_out_t beat_outcomes [$];
  int unsigned         mismatches = 0;

  function automatic logic [31:0] width_mask(input int t);
    return ctrl_bits[t][ddct_pkg::CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  endfunction

  task automatic restart_timer(input int t);
    count_val[t]    = reload_val[t] & width_mask(t);
    prescale_cnt[t] = '0;
    running[t]      = ctrl_bits[t][ddct_pkg::CTL_ENABLE];
  endtask

  task automatic tick_timer(input int t);
    int divide;
    if (!ctrl_bits[t][ddct_pkg::CTL_ENABLE] || !running[t]) return;
    case (ctrl_bits[t][3:2])
      ddct_pkg::PSC_DIV1:  divide = 1;
      ddct_pkg::PSC_DIV16: divide = 16;
      default:             divide = 256;
    endcase
    if (int'(prescale_cnt[t]) + 1 < divide) begin
      prescale_cnt[t] = prescale_cnt[t] + 8'd1;
      return;
    end
    prescale_cnt[t] = '0;
    if (count_val[t] > 32'd1) begin
      count_val[t] = count_val[t] - 32'd1;
      return;
    end
    // Expiry: the irq follows the interrupt enable, so it clears when that is off.
    irq_flag[t] = ctrl_bits[t][ddct_pkg::CTL_INTEN];
    if (ctrl_bits[t][ddct_pkg::CTL_ONESHOT]) begin
      count_val[t] = '0;
      running[t]   = 1'b0;
    end else begin
      count_val[t] = (ctrl_bits[t][ddct_pkg::CTL_PERIODIC] ? reload_val[t] : 32'hFFFF_FFFF)
                     & width_mask(t);
    end
  endtask

  task automatic advance_timers(input ddct_pkg::ddct_in_t b,
                                output ddct_pkg::ddct_out_t res);
    int          t;
    logic [11:0] off;
    logic [31:0] rd;
    rd  = '0;
    t   = -1;
    off = b.address;
    if (b.address < ddct_pkg::TIMER_SPAN) begin
      t = 0;
    end else if (b.address >= ddct_pkg::SECOND_TIMER_BASE &&
                 b.address - ddct_pkg::SECOND_TIMER_BASE < ddct_pkg::TIMER_SPAN) begin
      t   = 1;
      off = b.address - ddct_pkg::SECOND_TIMER_BASE;
    end
    if (b.operation == ddct_pkg::OP_TICK) begin
      tick_timer(0);
      tick_timer(1);
    end else if ((b.operation == ddct_pkg::OP_READ || b.operation == ddct_pkg::OP_WRITE)
                 && off[1:0] == 2'b00) begin
      if (t >= 0) begin
        if (b.operation == ddct_pkg::OP_READ) begin
          case (off[4:0])
            ddct_pkg::OFF_LOAD, ddct_pkg::OFF_BGLOAD: rd = reload_val[t];
            ddct_pkg::OFF_VALUE:
              rd = ctrl_bits[t][ddct_pkg::CTL_ENABLE] ? count_val[t] : reload_val[t];
            ddct_pkg::OFF_CTRL:  rd = {24'h0, ctrl_bits[t]};
            ddct_pkg::OFF_RIS:   rd = {31'h0, irq_flag[t]};
            ddct_pkg::OFF_MIS:
              rd = {31'h0, irq_flag[t] & ctrl_bits[t][ddct_pkg::CTL_INTEN]};
            default:             rd = '0;
          endcase
        end else begin
          case (off[4:0])
            ddct_pkg::OFF_LOAD: begin
              reload_val[t] = b.write_data;
              restart_timer(t);
            end
            ddct_pkg::OFF_CTRL: begin
              ctrl_bits[t] = b.write_data[7:0] & ddct_pkg::CTL_MASK;
              restart_timer(t);
            end
            ddct_pkg::OFF_INTCLR: irq_flag[t] = 1'b0;
            ddct_pkg::OFF_BGLOAD: reload_val[t] = b.write_data;
            default: ;
          endcase
        end
      end else if (b.operation == ddct_pkg::OP_READ) begin
        if (off == ddct_pkg::ADDR_ITCR) rd = test_ctrl;
        else if (off[11:4] == ddct_pkg::ADDR_PID_HI)
          rd = (ddct_pkg::PERIPH_ID >> (8 * off[3:2])) & 32'hFF;
        else if (off[11:4] == ddct_pkg::ADDR_CID_HI)
          rd = (ddct_pkg::CELL_ID >> (8 * off[3:2])) & 32'hFF;
      end else if (off == ddct_pkg::ADDR_ITCR) begin
        test_ctrl = b.write_data;
      end
    end
    res.read_data    = rd;
    res.irq_one      = irq_flag[0];
    res.irq_two      = irq_flag[1];
    res.irq_combined = irq_flag[0] | irq_flag[1];
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp,
                               input logic [31:0] act);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp, act);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ddct_pkg::ddct_out_t predicted;
    ddct_pkg::ddct_out_t want;
    if (!rst_ni) begin
      for (int t = 0; t < 2; t++) begin
        reload_val[t]   = '0;
        ctrl_bits[t]    = ddct_pkg::CTL_RESET;
        count_val[t]    = 32'hFFFF_FFFF;
        prescale_cnt[t] = '0;
        running[t]      = 1'b0;
        irq_flag[t]     = 1'b0;
      end
      test_ctrl = '0;
      beat_outcomes.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // A result passes through both the input and result registers after its input, so pop before push.
      if (out_valid_i && out_ready_i) begin
        if (beat_outcomes.size() == 0) begin
          note_mismatch("unrequested result beat, read_data", 32'h0, out_data_i.read_data);
        end else begin
          want = beat_outcomes.pop_front();
          if (out_data_i.read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, out_data_i.read_data);
          if (out_data_i.irq_one !== want.irq_one)
            note_mismatch("irq_one", want.irq_one, out_data_i.irq_one);
          if (out_data_i.irq_two !== want.irq_two)
            note_mismatch("irq_two", want.irq_two, out_data_i.irq_two);
          if (out_data_i.irq_combined !== want.irq_combined)
            note_mismatch("irq_combined", want.irq_combined, out_data_i.irq_combined);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_timers(in_data_i, predicted);
        beat_outcomes.push_back(predicted);
      end
      pending_o    <= beat_outcomes.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== verif/dual_down_counter_timer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the dual down-counter timer: clock, reset, beat stimulus and
// receiver stalls, plus the verdict. Depends on ddct_pkg, ddct_checker and the block.
module dual_down_counter_timer_tb;

  localparam int unsigned RANDOM_BEATS   = 450;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam logic [11:0] ADDR_ITOP      = 12'hF04;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [1:0]  PSC_DIV256     = 2'd2;
  localparam logic [1:0]  PSC_RESERVED   = 2'd3;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  ddct_pkg::ddct_in_t  in_data   = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ddct_pkg::ddct_out_t out_data;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         cycle_cnt = 0;
  logic                hold_request = 1'b0;

  dual_down_counter_timer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ddct_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, an eager stretch now and then, and one long hold-off.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned r;
    bit          long_done;
    stall_left = 0;
    long_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_request && !long_done) begin
        long_done  = 1'b1;
        stall_left = 300;
        out_ready <= 1'b0;
      end else if ((cycle_cnt / 250) % 4 == 1) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [11:0] reg_addr(input bit second, input logic [4:0] off);
    return (second ? ddct_pkg::SECOND_TIMER_BASE : 12'h000) + {7'b0, off};
  endfunction

  function automatic logic [31:0] load_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 20);
    if (r < 90) return $urandom_range(0, 300);
    return $urandom;
  endfunction

  // Mostly timer traffic that keeps counters running and expiring, with some noise.
  function automatic ddct_pkg::ddct_in_t random_beat();
    ddct_pkg::ddct_in_t b;
    int unsigned        r;
    logic [7:0]         ctl;
    r = $urandom_range(0, 99);
    b.operation  = ddct_pkg::OP_WRITE;
    b.address    = 12'($urandom_range(0, 4095));
    b.write_data = $urandom;
    if (r < 50) begin
      b.operation = ddct_pkg::OP_TICK;
    end else if (r < 62) begin
      b.operation = ddct_pkg::OP_READ;
      b.address   = reg_addr(1'($urandom_range(0, 1)), 5'($urandom_range(0, 7) * 4));
    end else if (r < 69) begin
      b.address = reg_addr(1'($urandom_range(0, 1)), ddct_pkg::OFF_INTCLR);
    end else if (r < 75) begin
      b.address    = reg_addr(1'($urandom_range(0, 1)), ddct_pkg::OFF_LOAD);
      b.write_data = load_value();
    end else if (r < 79) begin
      b.address    = reg_addr(1'($urandom_range(0, 1)), ddct_pkg::OFF_BGLOAD);
      b.write_data = load_value();
    end else if (r < 85) begin
      b.address = reg_addr(1'($urandom_range(0, 1)), ddct_pkg::OFF_CTRL);
      ctl = 8'($urandom);
      r   = $urandom_range(0, 99);
      ctl[3:2] = (r < 75) ? ddct_pkg::PSC_DIV1 : (r < 90) ? ddct_pkg::PSC_DIV16 :
                 (r < 97) ? PSC_DIV256 : PSC_RESERVED;
      ctl[ddct_pkg::CTL_ENABLE] = ($urandom_range(0, 99) < 85);
      b.write_data[7:0] = ctl;
    end else if (r < 90) begin
      b.operation = $urandom_range(0, 1) ? ddct_pkg::OP_READ : ddct_pkg::OP_WRITE;
      case ($urandom_range(0, 3))
        0:       b.address = ddct_pkg::ADDR_ITCR;
        1:       b.address = ADDR_ITOP;
        2:       b.address = {ddct_pkg::ADDR_PID_HI, 2'($urandom_range(0, 3)), 2'b00};
        default: b.address = {ddct_pkg::ADDR_CID_HI, 2'($urandom_range(0, 3)), 2'b00};
      endcase
    end else begin
      b.operation = 2'($urandom_range(0, 3));
    end
    return b;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [11:0] addr,
                           input logic [31:0] data, input bit allow_gap);
    int unsigned gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, address: addr, write_data: data};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The pending count is registered in the checker, hence the first wait.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    ddct_pkg::ddct_in_t b;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(ddct_pkg::OP_READ,  ddct_pkg::ADDR_ITCR, 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_WRITE, ddct_pkg::ADDR_ITCR, 32'hFFFF_FFFF, 1'b1);
    send_beat(ddct_pkg::OP_READ,  ddct_pkg::ADDR_ITCR, 32'hFFFF_FFFF, 1'b1);
    send_beat(ddct_pkg::OP_WRITE, ADDR_ITOP, 32'hFFFF_FFFF, 1'b1);
    send_beat(ddct_pkg::OP_READ,  ADDR_ITOP, 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  {ddct_pkg::ADDR_PID_HI, 4'h0}, 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  {ddct_pkg::ADDR_CID_HI, 4'hC}, 32'h0, 1'b1);
    // Timer one: periodic, 32-bit, interrupts on, expires after two ticks.
    send_beat(ddct_pkg::OP_WRITE, reg_addr(1'b0, ddct_pkg::OFF_LOAD), 32'd2, 1'b1);
    send_beat(ddct_pkg::OP_WRITE, reg_addr(1'b0, ddct_pkg::OFF_CTRL), 32'hFFFF_FFE2, 1'b1);
    send_beat(ddct_pkg::OP_TICK,  12'hFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(ddct_pkg::OP_TICK,  12'h000, 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b0, ddct_pkg::OFF_VALUE), 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b0, ddct_pkg::OFF_MIS), 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b0, ddct_pkg::OFF_RIS), 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_WRITE, reg_addr(1'b0, ddct_pkg::OFF_VALUE), 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_WRITE, reg_addr(1'b0, ddct_pkg::OFF_INTCLR), 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b0, ddct_pkg::OFF_INTCLR), 32'h0, 1'b1);
    // Timer two: a load that masks to zero in 16-bit mode, one-shot, reserved bit set.
    send_beat(ddct_pkg::OP_WRITE, reg_addr(1'b1, ddct_pkg::OFF_LOAD), 32'h0001_0000, 1'b1);
    send_beat(ddct_pkg::OP_WRITE, reg_addr(1'b1, ddct_pkg::OFF_CTRL), 32'h0000_00B1, 1'b1);
    send_beat(ddct_pkg::OP_TICK,  12'h000, 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b1, ddct_pkg::OFF_CTRL), 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b1, ddct_pkg::OFF_BGLOAD), 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b1, ddct_pkg::OFF_VALUE) + 12'd1, 32'h0, 1'b1);
    send_beat(ddct_pkg::OP_READ,  reg_addr(1'b0, 5'h1C), 32'h0, 1'b1);
    send_beat(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
    drain();

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 150) hold_request <= 1'b1;
      if (i == 300) drain();
      b = random_beat();
      send_beat(b.operation, b.address, b.write_data,
                !(i >= 150 && i < 200) && ((i / 40) % 3 != 2));
    end
    drain();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ddct_pkg.sv
hdl/ddct_timer.sv
hdl/dual_down_counter_timer.sv
hdl/ddct_checker.sv
verif/ddct_checker.sv
verif/dual_down_counter_timer_tb.sv
